@@ hdl/tgcs_pkg.sv @@
// Shared types, field widths, codes and helpers of the triple gene cover scorer.
`default_nettype none
package tgcs_pkg;

  localparam int GENE_W     = 10;
  localparam int WIDX_W     = 4;
  localparam int BITS_W     = 64;
  localparam int ALPHA_W    = 17;
  localparam int NN_W       = 11;
  localparam int SCORE_W    = 27;
  localparam int CNT_W      = 11;
  localparam int PROD_W     = ALPHA_W + CNT_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd6554;
  localparam logic [SCORE_W-1:0] SCORE_MAX   = {SCORE_W{1'b1}};

  typedef enum logic [1:0] {
    FUNC_LOAD_TUMOR  = 2'd0,
    FUNC_LOAD_NORMAL = 2'd1,
    FUNC_SCORE       = 2'd2,
    FUNC_COVER       = 2'd3
  } func_t;

  localparam logic KIND_BEST  = 1'b0;
  localparam logic KIND_COVER = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA        = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_COUNT = 1'b1;

  // Tag that travels with one row read, aligned with the memory latency.
  typedef struct packed {
    logic              valid;
    logic [1:0]        sel;
    logic [WIDX_W-1:0] word;
    logic              in_range;
  } rd_tag_t;

  typedef struct packed {
    logic              start;
    logic              is_cover;
    logic              load_tumor;
    logic [WIDX_W-1:0] load_word;
    rd_tag_t           rd;
  } acc_ctl_t;

  typedef struct packed {
    logic             busy;
    logic             all_covered;
    logic [CNT_W-1:0] tp;
    logic [CNT_W-1:0] fp;
  } acc_stat_t;

  typedef struct packed {
    logic mul_en;
    logic score_en;
    logic clear;
  } best_ctl_t;

  typedef struct packed {
    logic               valid;
    logic [SCORE_W-1:0] score;
    logic [GENE_W-1:0]  gene_a;
    logic [GENE_W-1:0]  gene_b;
    logic [GENE_W-1:0]  gene_c;
  } best_t;

  // Population count as eight byte counts followed by their sum.
  function automatic logic [6:0] pop64(input logic [63:0] x);
    logic [3:0] byte_cnt [8];
    logic [6:0] sum;
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      byte_cnt[i] = '0;
      for (int j = 0; j < 8; j++) begin
        byte_cnt[i] = byte_cnt[i] + 4'(x[8*i+j]);
      end
    end
    for (int i = 0; i < 8; i++) begin
      sum = sum + 7'(byte_cnt[i]);
    end
    return sum;
  endfunction

endpackage
`default_nettype wire

@@ hdl/tgcs_in_if.sv @@
// Request channel interface of the triple gene cover scorer.
`default_nettype none
interface tgcs_in_if;
  import tgcs_pkg::*;

  logic              valid;
  logic              ready;
  func_t             func;
  logic [GENE_W-1:0] gene_a;
  logic [GENE_W-1:0] gene_b;
  logic [GENE_W-1:0] gene_c;
  logic [WIDX_W-1:0] word_index;
  logic [BITS_W-1:0] bits;
  logic              last_triple;

  modport source (output valid, func, gene_a, gene_b, gene_c, word_index, bits,
                  last_triple, input ready);
  modport sink (input valid, func, gene_a, gene_b, gene_c, word_index, bits,
                last_triple, output ready);
endinterface
`default_nettype wire

@@ hdl/tgcs_out_if.sv @@
// Result channel interface of the triple gene cover scorer.
`default_nettype none
interface tgcs_out_if;
  import tgcs_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic               best_found;
  logic [SCORE_W-1:0] best_score;
  logic [GENE_W-1:0]  best_gene_a;
  logic [GENE_W-1:0]  best_gene_b;
  logic [GENE_W-1:0]  best_gene_c;
  logic [CNT_W-1:0]   newly_covered;
  logic               all_covered;

  modport source (output valid, kind, best_found, best_score, best_gene_a, best_gene_b,
                  best_gene_c, newly_covered, all_covered, input ready);
  modport sink (input valid, kind, best_found, best_score, best_gene_a, best_gene_b,
                best_gene_c, newly_covered, all_covered, output ready);
endinterface
`default_nettype wire

@@ hdl/tgcs_row_ram.sv @@
// Single-port-write, single-port-read bitmap row memory with registered read data.
`default_nettype none
module tgcs_row_ram #(
  parameter int DW = 64,
  parameter int AW = 14
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/tgcs_cover_acc.sv @@
// Row intersection, covered and seen masks, and TP/FP counters.
`default_nettype none
module tgcs_cover_acc #(
  parameter int WORD_BITS  = 64,
  parameter int WORDS_USED = 16,
  parameter int WB         = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire tgcs_pkg::acc_ctl_t        ctl,
  input  wire logic      [WORD_BITS-1:0] load_bits,
  input  wire logic      [WORD_BITS-1:0] rdata_t,
  input  wire logic      [WORD_BITS-1:0] rdata_n,
  output tgcs_pkg::acc_stat_t            stat
);
  import tgcs_pkg::*;

  rd_tag_t               tag_r;
  logic [WORD_BITS-1:0]  t_acc_r, n_acc_r;
  logic [WORD_BITS-1:0]  t_word_r, n_word_r;
  logic                  st2_valid_r;
  logic [WIDX_W-1:0]     st2_word_r;
  logic [CNT_W-1:0]      tp_r, fp_r;
  logic [WORD_BITS-1:0]  covered_r [WORDS_USED];
  logic [WORD_BITS-1:0]  seen_r [WORDS_USED];
  logic [WORDS_USED-1:0] mismatch_r;

  logic [WORD_BITS-1:0] d_t, d_n;
  logic [WB-1:0]        st2_idx, load_idx;
  logic [WORD_BITS-1:0] new_word, covered_upd, seen_upd;
  logic [6:0]           cnt_t, cnt_n;

  assign d_t = tag_r.in_range ? rdata_t : '0;
  assign d_n = tag_r.in_range ? rdata_n : '0;

  assign st2_idx     = st2_word_r[WB-1:0];
  assign load_idx    = ctl.load_word[WB-1:0];
  assign new_word    = t_word_r & ~covered_r[st2_idx];
  assign covered_upd = covered_r[st2_idx] | new_word;
  assign seen_upd    = seen_r[load_idx] | load_bits;
  assign cnt_t       = pop64(64'(new_word));
  assign cnt_n       = pop64(64'(n_word_r));

  // Stage one: AND the three rows of a word as they arrive.
  always_ff @(posedge clk) begin
    if (tag_r.valid) begin
      case (tag_r.sel)
        2'd0: begin
          t_acc_r <= d_t;
          n_acc_r <= d_n;
        end
        2'd1: begin
          t_acc_r <= t_acc_r & d_t;
          n_acc_r <= n_acc_r & d_n;
        end
        default: begin
          t_word_r   <= t_acc_r & d_t;
          n_word_r   <= n_acc_r & d_n;
          st2_word_r <= tag_r.word;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r       <= '0;
      st2_valid_r <= 1'b0;
      tp_r        <= '0;
      fp_r        <= '0;
      mismatch_r  <= '0;
      for (int i = 0; i < WORDS_USED; i++) begin
        covered_r[i] <= '0;
        seen_r[i]    <= '0;
      end
    end else begin
      tag_r       <= ctl.rd;
      st2_valid_r <= tag_r.valid && (tag_r.sel == 2'd2);
      if (ctl.start) begin
        tp_r <= '0;
        fp_r <= '0;
      end else if (st2_valid_r) begin
        // Stage two: count the word and fold it into the covered mask on a cover.
        tp_r <= tp_r + CNT_W'(cnt_t);
        fp_r <= fp_r + CNT_W'(cnt_n);
        if (ctl.is_cover) begin
          covered_r[st2_idx]  <= covered_upd;
          mismatch_r[st2_idx] <= covered_upd != seen_r[st2_idx];
        end
      end
      if (ctl.load_tumor) begin
        seen_r[load_idx]     <= seen_upd;
        mismatch_r[load_idx] <= covered_r[load_idx] != seen_upd;
      end
    end
  end

  assign stat.busy        = tag_r.valid || st2_valid_r;
  assign stat.all_covered = ~|mismatch_r;
  assign stat.tp          = tp_r;
  assign stat.fp          = fp_r;
endmodule
`default_nettype wire

@@ hdl/tgcs_best.sv @@
// Score arithmetic and the best-of-round registers.
`default_nettype none
module tgcs_best (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire tgcs_pkg::best_ctl_t             ctl,
  input  wire logic [tgcs_pkg::ALPHA_W-1:0]    alpha,
  input  wire logic [tgcs_pkg::NN_W-1:0]       normal_count,
  input  wire logic [tgcs_pkg::CNT_W-1:0]      tp,
  input  wire logic [tgcs_pkg::CNT_W-1:0]      fp,
  input  wire logic [tgcs_pkg::GENE_W-1:0]     gene_a,
  input  wire logic [tgcs_pkg::GENE_W-1:0]     gene_b,
  input  wire logic [tgcs_pkg::GENE_W-1:0]     gene_c,
  output tgcs_pkg::best_t                      best
);
  import tgcs_pkg::*;

  localparam int SUM_W = PROD_W + 2;

  logic [PROD_W-1:0]  prod_r;
  best_t              best_r;
  logic [SUM_W-1:0]   sum;
  logic [SCORE_W-1:0] score;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= PROD_W'(alpha) * PROD_W'(tp);
    end
  end

  // alpha*TP + (Nn - FP) * 2^16, clamped to the score range.
  assign sum = SUM_W'(prod_r) + SUM_W'({normal_count, 16'd0}) - SUM_W'({fp, 16'd0});

  always_comb begin
    if (sum[SUM_W-1]) begin
      score = '0;
    end else if (|sum[SUM_W-2:SCORE_W]) begin
      score = SCORE_MAX;
    end else begin
      score = sum[SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
    end else if (ctl.clear) begin
      best_r <= '0;
    end else if (ctl.score_en && (!best_r.valid || score >= best_r.score)) begin
      best_r.valid  <= 1'b1;
      best_r.score  <= score;
      best_r.gene_a <= gene_a;
      best_r.gene_b <= gene_b;
      best_r.gene_c <= gene_c;
    end
  end

  assign best = best_r;
endmodule
`default_nettype wire

@@ hdl/triple_gene_cover_scorer_core.sv @@
// Top level of the triple gene cover scorer: sequencer, configuration and result register.
`default_nettype none
// The block keeps a tumor and a normal bitmap row per gene in two row memories and
// scores gene triples against them. Requests arrive on in_ch (valid/ready, accepted
// when both are high); results leave on out_ch the same way. cfg_we/cfg_index/cfg_wdata
// write alpha (index 0) and the normal sample count (index 1); the user must write them
// only while the block is idle, which the block itself does not enforce.
//
// A load request is taken while the block is idle and gives no result. A score or cover
// request is taken while the block is idle and then walks the three rows word by word,
// one memory read per cycle on each row memory. The read and count pipeline then
// drains, a score passes the multiply and compare steps, and a report loads the
// result register. Only a score marked last in the round, or a cover, gives a result.
//
// The result register parts the two channels: new requests are taken while a result
// waits, and a later request that has its own result holds in its final step until
// the receiver has taken the earlier one. Reset clears the covered and seen masks and
// the best-of-round registers and sets alpha to 6554 and the normal count to zero;
// row memories are not cleared and must be loaded before they are read.
module triple_gene_cover_scorer_core #(
  parameter int GENE_COUNT   = 1024,
  parameter int SAMPLE_COUNT = 1024,
  parameter int WORD_BITS    = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  tgcs_in_if.sink                                 in_ch,
  tgcs_out_if.source                              out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [tgcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tgcs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tgcs_pkg::*;

  // Only words and genes that the request fields can address are stored.
  localparam int WORDS      = SAMPLE_COUNT / WORD_BITS;
  localparam int WORDS_USED = (WORDS > 16) ? 16 : WORDS;
  localparam int WB         = (WORDS_USED > 1) ? $clog2(WORDS_USED) : 1;
  localparam int GENES_USED = (GENE_COUNT > 1024) ? 1024 : GENE_COUNT;
  localparam int GB         = $clog2(GENES_USED);
  localparam int AW         = GB + WB;
  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(WORDS_USED - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RUN   = 6'b000010,
    S_DRAIN = 6'b000100,
    S_MUL   = 6'b001000,
    S_SCORE = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [GENE_W-1:0]  ga_r, gb_r, gc_r;
  logic [2:0]         rng_r;
  logic               is_cover_r, last_r;
  logic [1:0]         sel_r;
  logic [WIDX_W-1:0]  word_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [NN_W-1:0]    nn_r;

  logic               out_valid_r, out_kind_r, out_found_r, out_all_r;
  logic [SCORE_W-1:0] out_score_r;
  logic [GENE_W-1:0]  out_ga_r, out_gb_r, out_gc_r;
  logic [CNT_W-1:0]   out_newly_r;

  logic                 in_fire, is_work, is_load, load_ok, emit_fire;
  logic [GENE_W-1:0]    gene_sel;
  logic                 rng_sel;
  logic [AW-1:0]        waddr, raddr;
  logic [WORD_BITS-1:0] load_bits, rdata_t, rdata_n;
  acc_ctl_t             acc_ctl;
  acc_stat_t            acc_stat;
  best_ctl_t            best_ctl;
  best_t                best;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_work     = (in_ch.func == FUNC_SCORE) || (in_ch.func == FUNC_COVER);
  assign is_load     = (in_ch.func == FUNC_LOAD_TUMOR) || (in_ch.func == FUNC_LOAD_NORMAL);
  // Loads beyond the gene count or the row length are dropped.
  assign load_ok     = in_fire && is_load && (32'(in_ch.gene_a) < GENE_COUNT) &&
                       (32'(in_ch.word_index) < WORDS);
  assign load_bits   = in_ch.bits[WORD_BITS-1:0];
  assign emit_fire   = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  // Gene of the current read; an out-of-range gene reads as an all-zero row.
  always_comb begin
    case (sel_r)
      2'd0: begin
        gene_sel = ga_r;
        rng_sel  = rng_r[0];
      end
      2'd1: begin
        gene_sel = gb_r;
        rng_sel  = rng_r[1];
      end
      default: begin
        gene_sel = gc_r;
        rng_sel  = rng_r[2];
      end
    endcase
  end

  assign waddr = {in_ch.gene_a[GB-1:0], in_ch.word_index[WB-1:0]};
  assign raddr = {gene_sel[GB-1:0], word_r[WB-1:0]};

  tgcs_row_ram #(.DW(WORD_BITS), .AW(AW)) u_tumor_ram (
    .clk   (clk),
    .we    (load_ok && (in_ch.func == FUNC_LOAD_TUMOR)),
    .waddr (waddr),
    .wdata (load_bits),
    .raddr (raddr),
    .rdata (rdata_t)
  );

  tgcs_row_ram #(.DW(WORD_BITS), .AW(AW)) u_normal_ram (
    .clk   (clk),
    .we    (load_ok && (in_ch.func == FUNC_LOAD_NORMAL)),
    .waddr (waddr),
    .wdata (load_bits),
    .raddr (raddr),
    .rdata (rdata_n)
  );

  always_comb begin
    acc_ctl.start       = in_fire && is_work;
    acc_ctl.is_cover    = is_cover_r;
    acc_ctl.load_tumor  = load_ok && (in_ch.func == FUNC_LOAD_TUMOR);
    acc_ctl.load_word   = in_ch.word_index;
    acc_ctl.rd.valid    = (state_r == S_RUN);
    acc_ctl.rd.sel      = sel_r;
    acc_ctl.rd.word     = word_r;
    acc_ctl.rd.in_range = rng_sel;
  end

  tgcs_cover_acc #(.WORD_BITS(WORD_BITS), .WORDS_USED(WORDS_USED), .WB(WB)) u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (acc_ctl),
    .load_bits (load_bits),
    .rdata_t   (rdata_t),
    .rdata_n   (rdata_n),
    .stat      (acc_stat)
  );

  always_comb begin
    best_ctl.mul_en   = (state_r == S_MUL);
    best_ctl.score_en = (state_r == S_SCORE);
    best_ctl.clear    = emit_fire && !is_cover_r;
  end

  tgcs_best u_best (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (best_ctl),
    .alpha        (alpha_r),
    .normal_count (nn_r),
    .tp           (acc_stat.tp),
    .fp           (acc_stat.fp),
    .gene_a       (ga_r),
    .gene_b       (gb_r),
    .gene_c       (gc_r),
    .best         (best)
  );

  // Sequencer: three reads per word, drain, then score or report.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && is_work) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if ((sel_r == 2'd2) && (word_r == LAST_WORD)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!acc_stat.busy) begin
          state_nxt = is_cover_r ? S_EMIT : S_MUL;
        end
      end
      S_MUL:   state_nxt = S_SCORE;
      S_SCORE: state_nxt = last_r ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (emit_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= '0;
      word_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire && is_work) begin
        sel_r  <= '0;
        word_r <= '0;
      end else if (state_r == S_RUN) begin
        if (sel_r == 2'd2) begin
          sel_r  <= '0;
          word_r <= word_r + 1'b1;
        end else begin
          sel_r <= sel_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_work) begin
      ga_r       <= in_ch.gene_a;
      gb_r       <= in_ch.gene_b;
      gc_r       <= in_ch.gene_c;
      rng_r[0]   <= 32'(in_ch.gene_a) < GENE_COUNT;
      rng_r[1]   <= 32'(in_ch.gene_b) < GENE_COUNT;
      rng_r[2]   <= 32'(in_ch.gene_c) < GENE_COUNT;
      is_cover_r <= (in_ch.func == FUNC_COVER);
      last_r     <= in_ch.last_triple;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
      nn_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALPHA:        alpha_r <= cfg_wdata[ALPHA_W-1:0];
        CFG_NORMAL_COUNT: nn_r    <= cfg_wdata[NN_W-1:0];
      endcase
    end
  end

  // Result register; a cover report zeroes the best fields and vice versa.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_kind_r  <= is_cover_r ? KIND_COVER : KIND_BEST;
      out_found_r <= !is_cover_r && best.valid;
      out_score_r <= is_cover_r ? '0 : best.score;
      out_ga_r    <= is_cover_r ? '0 : best.gene_a;
      out_gb_r    <= is_cover_r ? '0 : best.gene_b;
      out_gc_r    <= is_cover_r ? '0 : best.gene_c;
      out_newly_r <= is_cover_r ? acc_stat.tp : '0;
      out_all_r   <= is_cover_r && acc_stat.all_covered;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_kind_r;
  assign out_ch.best_found    = out_found_r;
  assign out_ch.best_score    = out_score_r;
  assign out_ch.best_gene_a   = out_ga_r;
  assign out_ch.best_gene_b   = out_gb_r;
  assign out_ch.best_gene_c   = out_gc_r;
  assign out_ch.newly_covered = out_newly_r;
  assign out_ch.all_covered   = out_all_r;
endmodule
`default_nettype wire

@@ tb/triple_gene_cover_scorer_core_tb.sv @@
// Testbench of the triple gene cover scorer core: directed table, random rounds, scoreboard.
module triple_gene_cover_scorer_core_tb;
  import tgcs_pkg::*;

  // Geometry of the block as instantiated here.
  localparam int GENES     = 1024;
  localparam int ROW_WORDS = 16;

  // Run shape. SETTLE_CYCLES idle clocks after the last report are enough for any
  // request without a report to finish its walk.
  localparam int RANDOM_PER_PHASE = 72;
  localparam int SETTLE_CYCLES    = 80;
  localparam int HOLD_OFF_CYCLES  = 600;
  localparam int LIMIT_CYCLES     = 400000;
  localparam int MAX_REPORTED     = 10;

  localparam logic [BITS_W-1:0] ALL_SET = '1;

  typedef struct packed {
    func_t             func;
    logic [GENE_W-1:0] gene_a;
    logic [GENE_W-1:0] gene_b;
    logic [GENE_W-1:0] gene_c;
    logic [WIDX_W-1:0] word_index;
    logic [BITS_W-1:0] bits;
    logic              last_triple;
  } request_t;

  typedef struct packed {
    logic               kind;
    logic               best_found;
    logic [SCORE_W-1:0] best_score;
    logic [GENE_W-1:0]  best_gene_a;
    logic [GENE_W-1:0]  best_gene_b;
    logic [GENE_W-1:0]  best_gene_c;
    logic [CNT_W-1:0]   newly_covered;
    logic               all_covered;
  } report_t;

  // One row of the stimulus table. A fill row expands into one load per row word,
  // a settings row waits for the block to go idle and then writes both registers,
  // and the random row stands for the whole random part of the run.
  typedef enum {STEP_ITEM, STEP_FILL, STEP_CFG, STEP_RANDOM} step_kind_t;

  typedef struct {
    step_kind_t         kind;
    request_t           req;
    bit                 typed;
    report_t            want;
    logic [ALPHA_W-1:0] alpha;
    logic [NN_W-1:0]    nn;
  } step_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tgcs_in_if  in_ch ();
  tgcs_out_if out_ch ();

  triple_gene_cover_scorer_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the block's state. Row words are only read for genes whose tumor and
  // normal rows have been written in full, which the written flags keep track of.
  logic [BITS_W-1:0]    tumor_mem  [GENES][ROW_WORDS];
  logic [BITS_W-1:0]    normal_mem [GENES][ROW_WORDS];
  bit   [ROW_WORDS-1:0] tumor_written  [GENES];
  bit   [ROW_WORDS-1:0] normal_written [GENES];
  bit                   gene_listed [GENES];
  int                   ready_genes [$];
  logic [BITS_W-1:0]    covered_words [ROW_WORDS];
  logic [BITS_W-1:0]    seen_words    [ROW_WORDS];
  logic [SCORE_W-1:0]   round_best_score;
  logic [GENE_W-1:0]    round_best_a;
  logic [GENE_W-1:0]    round_best_b;
  logic [GENE_W-1:0]    round_best_c;
  bit                   round_best_valid;
  logic [ALPHA_W-1:0]   alpha_setting;
  logic [NN_W-1:0]      normal_setting;

  // Reports the block owes us, oldest first.
  report_t pending_reports [$];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off_req;
  int hold_left;
  int failures;
  int requests_sent;
  int best_reports;
  int cover_reports;
  int settings_written;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Applies one accepted request to the mirrored state. Returns 1 when the request
  // produces a report, which is then handed back in rep.
  function automatic bit scorer_outcome(input request_t r, output report_t rep);
    logic [BITS_W-1:0] hit;
    longint            tp;
    longint            fp;
    longint            s;
    bit                all_eq;
    rep = '0;
    tp  = 0;
    fp  = 0;
    case (r.func)
      FUNC_LOAD_TUMOR, FUNC_LOAD_NORMAL: begin
        if (r.func == FUNC_LOAD_TUMOR) begin
          tumor_mem[r.gene_a][r.word_index]     = r.bits;
          tumor_written[r.gene_a][r.word_index] = 1'b1;
          seen_words[r.word_index]              = seen_words[r.word_index] | r.bits;
        end else begin
          normal_mem[r.gene_a][r.word_index]     = r.bits;
          normal_written[r.gene_a][r.word_index] = 1'b1;
        end
        if (&tumor_written[r.gene_a] && &normal_written[r.gene_a] &&
            !gene_listed[r.gene_a]) begin
          gene_listed[r.gene_a] = 1'b1;
          ready_genes.insert(ready_genes.size(), int'(r.gene_a));
        end
        return 1'b0;
      end
      FUNC_SCORE: begin
        for (int w = 0; w < ROW_WORDS; w++) begin
          hit = tumor_mem[r.gene_a][w] & tumor_mem[r.gene_b][w] & tumor_mem[r.gene_c][w] &
                ~covered_words[w];
          tp += $countones(hit);
          fp += $countones(normal_mem[r.gene_a][w] & normal_mem[r.gene_b][w] &
                           normal_mem[r.gene_c][w]);
        end
        s = longint'(alpha_setting) * tp + (longint'(normal_setting) - fp) * 65536;
        if (s < 0) begin
          s = 0;
        end
        if (s > longint'(SCORE_MAX)) begin
          s = longint'(SCORE_MAX);
        end
        // Ties go to the later triple, so the compare is greater-or-equal.
        if (!round_best_valid || s[SCORE_W-1:0] >= round_best_score) begin
          round_best_score = s[SCORE_W-1:0];
          round_best_a     = r.gene_a;
          round_best_b     = r.gene_b;
          round_best_c     = r.gene_c;
          round_best_valid = 1'b1;
        end
        if (!r.last_triple) begin
          return 1'b0;
        end
        rep.kind         = KIND_BEST;
        rep.best_found   = round_best_valid;
        rep.best_score   = round_best_score;
        rep.best_gene_a  = round_best_a;
        rep.best_gene_b  = round_best_b;
        rep.best_gene_c  = round_best_c;
        round_best_valid = 1'b0;
        round_best_score = '0;
        round_best_a     = '0;
        round_best_b     = '0;
        round_best_c     = '0;
        return 1'b1;
      end
      default: begin
        for (int w = 0; w < ROW_WORDS; w++) begin
          hit = tumor_mem[r.gene_a][w] & tumor_mem[r.gene_b][w] & tumor_mem[r.gene_c][w] &
                ~covered_words[w];
          tp += $countones(hit);
          covered_words[w] = covered_words[w] | hit;
        end
        all_eq = 1'b1;
        for (int w = 0; w < ROW_WORDS; w++) begin
          if (covered_words[w] != seen_words[w]) begin
            all_eq = 1'b0;
          end
        end
        rep.kind          = KIND_COVER;
        rep.newly_covered = tp[CNT_W-1:0];
        rep.all_covered   = all_eq;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic string describe(input report_t p);
    return $sformatf("kind=%0d found=%0d score=%0d genes=%0d,%0d,%0d newly=%0d all=%0d",
                     p.kind, p.best_found, p.best_score, p.best_gene_a, p.best_gene_b,
                     p.best_gene_c, p.newly_covered, p.all_covered);
  endfunction

  // Bitmap words of mixed density: all set, all clear, plain random, and two
  // denser mixes so that three-way intersections are not always nearly empty.
  // A draw of four keeps the plain random word.
  function automatic logic [BITS_W-1:0] random_word();
    logic [BITS_W-1:0] x;
    x = {$urandom, $urandom};
    case ($urandom_range(4))
      0: x = '1;
      1: x = '0;
      2: x = x | {$urandom, $urandom};
      3: x = x | {$urandom, $urandom} | {$urandom, $urandom};
      default: x = x;
    endcase
    return x;
  endfunction

  // A load request; the fields that a load ignores carry random values.
  function automatic request_t load_request(input func_t f, input logic [GENE_W-1:0] gene,
                                            input logic [WIDX_W-1:0] word,
                                            input logic [BITS_W-1:0] pattern);
    request_t r;
    r.func        = f;
    r.gene_a      = gene;
    r.gene_b      = GENE_W'($urandom);
    r.gene_c      = GENE_W'($urandom);
    r.word_index  = word;
    r.bits        = pattern;
    r.last_triple = 1'($urandom);
    return r;
  endfunction

  // A score or cover request over three fully loaded genes.
  function automatic request_t triple_request(input func_t f, input bit last);
    request_t r;
    r.func        = f;
    r.gene_a      = GENE_W'(ready_genes[$urandom_range(ready_genes.size() - 1)]);
    r.gene_b      = GENE_W'(ready_genes[$urandom_range(ready_genes.size() - 1)]);
    r.gene_c      = GENE_W'(ready_genes[$urandom_range(ready_genes.size() - 1)]);
    r.word_index  = WIDX_W'($urandom);
    r.bits        = {$urandom, $urandom};
    r.last_triple = last;
    return r;
  endfunction

  function automatic step_t blank_step(input step_kind_t k);
    step_t s;
    s.kind  = k;
    s.req   = '0;
    s.typed = 1'b0;
    s.want  = '0;
    s.alpha = '0;
    s.nn    = '0;
    return s;
  endfunction

  function automatic step_t fill_row(input func_t f, input logic [GENE_W-1:0] gene,
                                     input logic [BITS_W-1:0] pattern);
    step_t s;
    s            = blank_step(STEP_FILL);
    s.req.func   = f;
    s.req.gene_a = gene;
    s.req.bits   = pattern;
    return s;
  endfunction

  function automatic step_t ask(input func_t f, input logic [GENE_W-1:0] a,
                                input logic [GENE_W-1:0] b, input logic [GENE_W-1:0] c,
                                input logic last);
    step_t s;
    s                 = blank_step(STEP_ITEM);
    s.req.func        = f;
    s.req.gene_a      = a;
    s.req.gene_b      = b;
    s.req.gene_c      = c;
    s.req.last_triple = last;
    return s;
  endfunction

  // A last-of-round score whose report is known by inspection.
  function automatic step_t ask_best(input logic [GENE_W-1:0] a, input logic [GENE_W-1:0] b,
                                     input logic [GENE_W-1:0] c,
                                     input logic [SCORE_W-1:0] score,
                                     input logic [GENE_W-1:0] ea, input logic [GENE_W-1:0] eb,
                                     input logic [GENE_W-1:0] ec);
    step_t s;
    s                  = ask(FUNC_SCORE, a, b, c, 1'b1);
    s.typed            = 1'b1;
    s.want.kind        = KIND_BEST;
    s.want.best_found  = 1'b1;
    s.want.best_score  = score;
    s.want.best_gene_a = ea;
    s.want.best_gene_b = eb;
    s.want.best_gene_c = ec;
    return s;
  endfunction

  function automatic step_t ask_cover(input logic [GENE_W-1:0] a, input logic [GENE_W-1:0] b,
                                      input logic [GENE_W-1:0] c, input logic last,
                                      input logic [CNT_W-1:0] newly, input logic all);
    step_t s;
    s                    = ask(FUNC_COVER, a, b, c, last);
    s.typed              = 1'b1;
    s.want.kind          = KIND_COVER;
    s.want.newly_covered = newly;
    s.want.all_covered   = all;
    return s;
  endfunction

  function automatic step_t settings(input logic [ALPHA_W-1:0] alpha,
                                     input logic [NN_W-1:0] nn);
    step_t s;
    s       = blank_step(STEP_CFG);
    s.alpha = alpha;
    s.nn    = nn;
    return s;
  endfunction

  // Offers one request and waits for the handshake. Valid stays high after the
  // handshake so that back-to-back requests never lower and raise it in one step;
  // it drops only when the sender idles or the block is drained.
  task automatic push_request(input request_t r, input bit typed, input report_t want);
    report_t rep;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= r.func;
    in_ch.gene_a      <= r.gene_a;
    in_ch.gene_b      <= r.gene_b;
    in_ch.gene_c      <= r.gene_c;
    in_ch.word_index  <= r.word_index;
    in_ch.bits        <= r.bits;
    in_ch.last_triple <= r.last_triple;
    do begin
      @(posedge clk);
    end while (in_ch.ready !== 1'b1);
    requests_sent++;
    if (scorer_outcome(r, rep)) begin
      pending_reports.insert(pending_reports.size(), typed ? want : rep);
    end
  endtask

  // Waits until every owed report has arrived, then lets a request without a report
  // finish its row walk, so that the block is idle afterwards.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) begin
      @(posedge clk);
    end
  endtask

  // Writes both registers on consecutive edges. The normal count carries random
  // bits above its width, which the block drops.
  task automatic write_settings(input logic [ALPHA_W-1:0] alpha, input logic [NN_W-1:0] nn);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ALPHA;
    cfg_wdata <= alpha;
    @(posedge clk);
    cfg_index <= CFG_NORMAL_COUNT;
    cfg_wdata <= {(CFG_DATA_W - NN_W)'($urandom), nn};
    @(posedge clk);
    cfg_we         <= 1'b0;
    alpha_setting  = alpha;
    normal_setting = nn;
    settings_written++;
  endtask

  // Result side: checks every handshake against the oldest owed report and drives
  // ready, either at random, or held low for a long stretch on request so that the
  // result register fills and the block stops taking requests.
  initial begin : result_sink
    report_t got;
    report_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.kind          = out_ch.kind;
        got.best_found    = out_ch.best_found;
        got.best_score    = out_ch.best_score;
        got.best_gene_a   = out_ch.best_gene_a;
        got.best_gene_b   = out_ch.best_gene_b;
        got.best_gene_c   = out_ch.best_gene_c;
        got.newly_covered = out_ch.newly_covered;
        got.all_covered   = out_ch.all_covered;
        if (pending_reports.size() == 0) begin
          failures++;
          if (failures <= MAX_REPORTED) begin
            $display("unexpected report: %s", describe(got));
          end
        end else begin
          want = pending_reports.pop_front();
          if (want.kind == KIND_BEST) begin
            best_reports++;
          end else begin
            cover_reports++;
          end
          if (got !== want) begin
            failures++;
            if (failures <= MAX_REPORTED) begin
              $display("report mismatch, expected %s", describe(want));
              $display("                 actual   %s", describe(got));
            end
          end
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Whatever goes wrong, the run ends here at the latest.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    step_t             plan [$];
    int                pool [$];
    request_t          r;
    request_t          base;
    report_t           none;
    int                sel;
    logic [GENE_W-1:0] g;

    // Every input of the block is known from time zero on.
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_ALPHA;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.func        <= FUNC_LOAD_TUMOR;
    in_ch.gene_a      <= '0;
    in_ch.gene_b      <= '0;
    in_ch.gene_c      <= '0;
    in_ch.word_index  <= '0;
    in_ch.bits        <= '0;
    in_ch.last_triple <= 1'b0;

    none = '0;
    for (int w = 0; w < ROW_WORDS; w++) begin
      covered_words[w] = '0;
      seen_words[w]    = '0;
    end
    round_best_valid = 1'b0;
    round_best_score = '0;
    round_best_a     = '0;
    round_best_b     = '0;
    round_best_c     = '0;
    alpha_setting    = ALPHA_RESET;
    normal_setting   = '0;
    send_idle_pct    = 32;
    recv_idle_pct    = 53;
    hold_off_req     = 1'b0;
    hold_left        = 0;

    // Gene 1023 is all tumor and no normal, gene 0 the other way round, so the
    // scores of the directed rows below follow directly from alpha and Nn.
    plan.insert(plan.size(), fill_row(FUNC_LOAD_TUMOR, 10'd1023, ALL_SET));
    plan.insert(plan.size(), fill_row(FUNC_LOAD_NORMAL, 10'd1023, '0));
    plan.insert(plan.size(), fill_row(FUNC_LOAD_TUMOR, 10'd0, '0));
    plan.insert(plan.size(), fill_row(FUNC_LOAD_NORMAL, 10'd0, ALL_SET));
    // Settings after reset: alpha 6554, Nn 0. A negative score clamps at zero.
    plan.insert(plan.size(), ask(FUNC_SCORE, 10'd0, 10'd0, 10'd0, 1'b0));
    plan.insert(plan.size(), ask_best(10'd1023, 10'd1023, 10'd1023, 27'd6711296,
                                      10'd1023, 10'd1023, 10'd1023));
    plan.insert(plan.size(), ask_best(10'd0, 10'd0, 10'd0, 27'd0, 10'd0, 10'd0, 10'd0));
    // Largest settings: full tumor weight saturates, a lower score does not win.
    plan.insert(plan.size(), settings(17'd65536, 11'd1024));
    plan.insert(plan.size(), ask(FUNC_SCORE, 10'd1023, 10'd1023, 10'd1023, 1'b0));
    plan.insert(plan.size(), ask_best(10'd0, 10'd0, 10'd0, SCORE_MAX,
                                      10'd1023, 10'd1023, 10'd1023));
    // Two equal scores in one round: the later triple is reported.
    plan.insert(plan.size(), ask(FUNC_SCORE, 10'd0, 10'd1023, 10'd0, 1'b0));
    plan.insert(plan.size(), ask_best(10'd1023, 10'd0, 10'd1023, 27'd67108864,
                                      10'd1023, 10'd0, 10'd1023));
    // Smallest settings, then a cover that adds nothing while samples stay uncovered.
    plan.insert(plan.size(), settings(17'd0, 11'd0));
    plan.insert(plan.size(), ask_best(10'd1023, 10'd1023, 10'd1023, 27'd0,
                                      10'd1023, 10'd1023, 10'd1023));
    plan.insert(plan.size(), ask_cover(10'd0, 10'd0, 10'd0, 1'b1, 11'd0, 1'b0));
    plan.insert(plan.size(), blank_step(STEP_RANDOM));
    // Closing rows: covering with an all-tumor gene covers every seen sample, and a
    // second such cover adds nothing. A full cover would starve the random part of
    // true positives, which is why these rows come last.
    plan.insert(plan.size(), fill_row(FUNC_LOAD_TUMOR, 10'd1023, ALL_SET));
    plan.insert(plan.size(), ask(FUNC_COVER, 10'd1023, 10'd1023, 10'd1023, 1'b0));
    plan.insert(plan.size(), ask_cover(10'd1023, 10'd1023, 10'd1023, 1'b0, 11'd0, 1'b1));
    plan.insert(plan.size(), ask(FUNC_SCORE, 10'd1023, 10'd1023, 10'd1023, 1'b1));

    repeat (11) begin
      @(posedge clk);
    end
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      case (plan[i].kind)
        STEP_ITEM: begin
          push_request(plan[i].req, plan[i].typed, plan[i].want);
        end
        STEP_FILL: begin
          for (int w = 0; w < ROW_WORDS; w++) begin
            base            = plan[i].req;
            base.word_index = WIDX_W'(w);
            push_request(base, 1'b0, none);
          end
        end
        STEP_CFG: begin
          drain();
          write_settings(plan[i].alpha, plan[i].nn);
        end
        default: begin
          // Load a pool of genes whose indexes together set and clear every bit,
          // so that gene_b and gene_c of scored triples take both values too.
          pool.delete();
          pool.insert(pool.size(), 10'h155);
          pool.insert(pool.size(), 10'h2AA);
          repeat (4) begin
            pool.insert(pool.size(), $urandom_range(GENES - 1));
          end
          foreach (pool[p]) begin
            for (int w = 0; w < ROW_WORDS; w++) begin
              r = load_request(FUNC_LOAD_TUMOR, GENE_W'(pool[p]), WIDX_W'(w), random_word());
              push_request(r, 1'b0, none);
              r = load_request(FUNC_LOAD_NORMAL, GENE_W'(pool[p]), WIDX_W'(w), random_word());
              push_request(r, 1'b0, none);
            end
          end
          // Three phases of random rounds with fresh settings each: both sides
          // idling, the idling swapped, and then neither idling.
          for (int phase = 0; phase < 3; phase++) begin
            drain();
            send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 53 : 0;
            recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 32 : 0;
            write_settings(ALPHA_W'($urandom_range(65536)), NN_W'($urandom_range(1024)));
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
              if (phase == 0 && n == 20) begin
                hold_off_req = 1'b1;
              end
              sel = $urandom_range(99);
              if (sel < 12) begin
                // Rewrite a word of a loaded gene, so scores keep moving.
                g = GENE_W'(ready_genes[$urandom_range(ready_genes.size() - 1)]);
                r = load_request($urandom_range(1) ? FUNC_LOAD_NORMAL : FUNC_LOAD_TUMOR, g,
                                 WIDX_W'($urandom), random_word());
              end else if (sel < 20) begin
                // Loads anywhere; a gene is only scored once both rows are complete.
                r = load_request($urandom_range(1) ? FUNC_LOAD_NORMAL : FUNC_LOAD_TUMOR,
                                 GENE_W'($urandom), WIDX_W'($urandom), {$urandom, $urandom});
              end else if (sel < 23) begin
                // Covers are rare: the covered mask never shrinks.
                r = triple_request(FUNC_COVER, 1'($urandom));
              end else begin
                r = triple_request(FUNC_SCORE, $urandom_range(99) < 30);
              end
              push_request(r, 1'b0, none);
            end
          end
        end
      endcase
    end

    drain();
    $display("Sent %0d requests under %0d settings; checked %0d best-of-round, %0d cover.",
             requests_sent, settings_written, best_reports, cover_reports);
    $display("Triples came from %0d fully loaded genes; %0d failures seen.",
             ready_genes.size(), failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/tgcs_pkg.sv
hdl/tgcs_in_if.sv
hdl/tgcs_out_if.sv
hdl/tgcs_row_ram.sv
hdl/tgcs_cover_acc.sv
hdl/tgcs_best.sv
hdl/triple_gene_cover_scorer_core.sv
tb/triple_gene_cover_scorer_core_tb.sv
